FILE: rtl/json_event_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// json_event_tokenizer_defines
// Assertion macros for the JSON event tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef JSON_EVENT_TOKENIZER_DEFINES_SVH
`define JSON_EVENT_TOKENIZER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define JET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define JET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// Types, codes and constants shared by the JSON event tokenizer.
// ----------------------------------------------------------------------------
package jet_pkg;

	localparam int MAX_DEPTH     = 32;
	localparam int POSITION_BITS = 24;
	localparam int LEVEL_BITS    = $clog2(MAX_DEPTH + 1);
	localparam int IDX_BITS      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int MAX_RES       = 3;
	localparam int CNT_BITS      = 2;

	localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

	typedef enum logic [3:0] {
		EV_OPEN_OBJ   = 4'd0,
		EV_CLOSE_OBJ  = 4'd1,
		EV_OPEN_LIST  = 4'd2,
		EV_CLOSE_LIST = 4'd3,
		EV_KEY        = 4'd4,
		EV_STRING     = 4'd5,
		EV_INT        = 4'd6,
		EV_BOOL       = 4'd7,
		EV_NULL       = 4'd8,
		EV_DONE       = 4'd9,
		EV_ERROR      = 4'd10
	} event_t;

	typedef enum logic [3:0] {
		PH_VALUE, PH_LIST_FIRST, PH_OBJ_FIRST, PH_OBJ_KEY, PH_KEY_STR, PH_COLON,
		PH_VAL_STR, PH_NUMBER, PH_LITERAL, PH_AFTER, PH_TOP_END, PH_FAILED
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_doc;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [30:0] int_value;
		logic        bool_value;
		logic [23:0] text_offset;
		logic [23:0] text_length;
		logic        last_of_run;
	} out_item_t;

	// results of one byte
	typedef struct packed {
		out_item_t [MAX_RES-1:0] res;
		logic [CNT_BITS-1:0]     count;
	} batch_t;

	// literal character table: kind 0 true, 1 false, 2 null
	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		unique case (k)
			2'd0: c = (i == 3'd1) ? "r" : (i == 3'd2) ? "u" : (i == 3'd3) ? "e" : 8'h00;
			2'd1: c = (i == 3'd1) ? "a" : (i == 3'd2) ? "l" : (i == 3'd3) ? "s" :
				(i == 3'd4) ? "e" : 8'h00;
			2'd2: c = (i == 3'd1) ? "u" : (i == 3'd2) ? "l" : (i == 3'd3) ? "l" : 8'h00;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] k);
		return (k == 2'd1) ? 3'd5 : 3'd4;
	endfunction

endpackage

FILE: rtl/jet_parse.sv
// ----------------------------------------------------------------------------
// jet_parse
// Per-byte parser: state registers, nesting stack, result batch register.
// ----------------------------------------------------------------------------
module jet_parse import jet_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output batch_t   batch
);

	phase_t                     phase_q;
	logic [LEVEL_BITS-1:0]      level_q;
	logic [POSITION_BITS-1:0]   pos_q, sstart_q;
	logic [30:0]                acc_q;
	logic [2:0]                 lidx_q;
	logic [1:0]                 lkind_q;
	logic [MAX_DEPTH-1:0]       kinds_q;

	phase_t                     ph_n;
	logic [LEVEL_BITS-1:0]      level_n;
	logic [POSITION_BITS-1:0]   sstart_n, pos_inc, slen;
	logic [30:0]                acc_n;
	logic [2:0]                 lidx_n;
	logic [1:0]                 lkind_n;
	logic                       push, push_kind;
	batch_t                     b;
	logic [7:0]                 c;
	logic                       ws, dig, top_kind;
	logic [34:0]                mul;

	assign c        = item.data_byte;
	assign ws       = (c == 8'h20) || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09);
	assign dig      = (c >= "0") && (c <= "9");
	assign pos_inc  = pos_q + 1'b1;
	assign slen     = pos_q - sstart_q;
	assign top_kind = (level_q == '0) ? 1'b0 : kinds_q[IDX_BITS'(level_q - 1'b1)];
	assign mul      = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {27'd0, c - 8'h30};

	always_comb begin
		phase_t ph;
		logic   fail;
		out_item_t r;
		b        = '0;
		ph       = phase_q;
		level_n  = level_q;
		sstart_n = sstart_q;
		acc_n    = acc_q;
		lidx_n   = lidx_q;
		lkind_n  = lkind_q;
		push     = 1'b0;
		push_kind = 1'b0;
		fail     = 1'b0;
		r        = '0;

		if (phase_q == PH_NUMBER && !dig) begin
			r = '0; r.event_res = EV_INT; r.int_value = acc_q;
			b.res[b.count] = r; b.count = b.count + 1'b1;
			ph = (level_q == '0) ? PH_TOP_END : PH_AFTER;
		end

		// per-phase step; the value start is shared by PH_VALUE and PH_LIST_FIRST
		unique case (ph)
			PH_VALUE, PH_LIST_FIRST: begin
				if (ws) begin
				end else if (ph == PH_LIST_FIRST && c == "]") begin
					if (level_q == '0 || !top_kind) fail = 1'b1;
					else begin
						level_n = level_q - 1'b1;
						r = '0; r.event_res = EV_CLOSE_LIST;
						b.res[b.count] = r; b.count = b.count + 1'b1;
						ph = (level_n == '0) ? PH_TOP_END : PH_AFTER;
					end
				end else if (c == "{" || c == "[") begin
					if (level_q >= LEVEL_BITS'(MAX_DEPTH)) fail = 1'b1;
					else begin
						push = 1'b1; push_kind = (c == "[");
						level_n = level_q + 1'b1;
						r = '0; r.event_res = (c == "[") ? EV_OPEN_LIST : EV_OPEN_OBJ;
						b.res[b.count] = r; b.count = b.count + 1'b1;
						ph = (c == "[") ? PH_LIST_FIRST : PH_OBJ_FIRST;
					end
				end else if (c == "\"") begin
					sstart_n = pos_inc; ph = PH_VAL_STR;
				end else if (dig) begin
					acc_n = 31'(c - 8'h30); ph = PH_NUMBER;
				end else if (c == "t" || c == "f" || c == "n") begin
					lkind_n = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
					lidx_n = 3'd1; ph = PH_LITERAL;
				end else fail = 1'b1;
			end
			PH_OBJ_FIRST, PH_OBJ_KEY: begin
				if (ws) begin
				end else if (c == "\"") begin
					sstart_n = pos_inc; ph = PH_KEY_STR;
				end else if (ph == PH_OBJ_FIRST && c == "}") begin
					if (level_q == '0 || top_kind) fail = 1'b1;
					else begin
						level_n = level_q - 1'b1;
						r = '0; r.event_res = EV_CLOSE_OBJ;
						b.res[b.count] = r; b.count = b.count + 1'b1;
						ph = (level_n == '0) ? PH_TOP_END : PH_AFTER;
					end
				end else fail = 1'b1;
			end
			PH_KEY_STR, PH_VAL_STR: begin
				if (c == "\"") begin
					r = '0;
					r.event_res = (ph == PH_KEY_STR) ? EV_KEY : EV_STRING;
					r.text_offset = 24'(sstart_q); r.text_length = 24'(slen);
					b.res[b.count] = r; b.count = b.count + 1'b1;
					ph = (ph == PH_KEY_STR) ? PH_COLON :
						(level_q == '0) ? PH_TOP_END : PH_AFTER;
				end
			end
			PH_COLON: begin
				if (ws) begin
				end else if (c == ":") ph = PH_VALUE;
				else fail = 1'b1;
			end
			PH_NUMBER: begin
				acc_n = (mul > {4'd0, INT_MAX31}) ? INT_MAX31 : mul[30:0];
			end
			PH_LITERAL: begin
				if (lkind_q == 2'd3 || lidx_q >= lit_len(lkind_q) ||
						c != lit_char(lkind_q, lidx_q)) fail = 1'b1;
				else if (lidx_q + 1'b1 == lit_len(lkind_q)) begin
					r = '0;
					r.event_res = (lkind_q == 2'd2) ? EV_NULL : EV_BOOL;
					r.bool_value = (lkind_q == 2'd0);
					b.res[b.count] = r; b.count = b.count + 1'b1;
					lidx_n = 3'd0;
					ph = (level_q == '0) ? PH_TOP_END : PH_AFTER;
				end else lidx_n = lidx_q + 1'b1;
			end
			PH_AFTER: begin
				if (ws) begin
				end else if (c == ",") begin
					if (level_q == '0) fail = 1'b1;
					else ph = top_kind ? PH_VALUE : PH_OBJ_KEY;
				end else if (c == "}" || c == "]") begin
					if (level_q == '0 || top_kind != (c == "]")) fail = 1'b1;
					else begin
						level_n = level_q - 1'b1;
						r = '0; r.event_res = (c == "]") ? EV_CLOSE_LIST : EV_CLOSE_OBJ;
						b.res[b.count] = r; b.count = b.count + 1'b1;
						ph = (level_n == '0) ? PH_TOP_END : PH_AFTER;
					end
				end else fail = 1'b1;
			end
			PH_TOP_END: if (!ws) fail = 1'b1;
			PH_FAILED: begin
			end
			default: fail = 1'b1;
		endcase

		if (fail) begin
			r = '0; r.event_res = EV_ERROR;
			b.res[b.count] = r; b.count = b.count + 1'b1;
			ph = PH_FAILED;
		end

		if (item.end_of_doc && ph != PH_FAILED) begin
			if (ph == PH_NUMBER) begin
				r = '0; r.event_res = EV_INT; r.int_value = acc_n;
				b.res[b.count] = r; b.count = b.count + 1'b1;
				ph = (level_n == '0) ? PH_TOP_END : PH_AFTER;
			end
			r = '0; r.event_res = (ph == PH_TOP_END) ? EV_DONE : EV_ERROR;
			b.res[b.count] = r; b.count = b.count + 1'b1;
		end

		if (b.count != '0) b.res[b.count - 1'b1].last_of_run = 1'b1;
		ph_n = ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_VALUE;
			level_q  <= '0;
			pos_q    <= '0;
			sstart_q <= '0;
			acc_q    <= '0;
			lidx_q   <= '0;
			lkind_q  <= '0;
			batch    <= '0;
		end else if (step) begin
			batch <= b;
			if (item.end_of_doc) begin
				phase_q  <= PH_VALUE;
				level_q  <= '0;
				pos_q    <= '0;
				sstart_q <= '0;
				acc_q    <= '0;
				lidx_q   <= '0;
				lkind_q  <= '0;
			end else begin
				phase_q  <= ph_n;
				level_q  <= level_n;
				pos_q    <= pos_inc;
				sstart_q <= sstart_n;
				acc_q    <= acc_n;
				lidx_q   <= lidx_n;
				lkind_q  <= lkind_n;
			end
		end
	end

	// stack bits carry no reset
	always_ff @(posedge clk) begin
		if (step && push) kinds_q[IDX_BITS'(level_q)] <= push_kind;
	end

endmodule

FILE: rtl/jet_drain.sv
// ----------------------------------------------------------------------------
// jet_drain
// Hands out the results of one byte one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jet_drain import jet_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  batch_t    batch,
	output logic      busy,
	output logic      out_valid,
	output out_item_t out_item,
	input  logic      out_ready
);

	logic [CNT_BITS-1:0] idx_q;
	logic                pend_q;

	// pend_q: batch register holds an unread batch (may be empty)
	assign out_valid = pend_q && (batch.count != '0);
	assign out_item  = batch.res[idx_q];
	assign busy      = pend_q && !(batch.count == '0 ||
		(out_ready && idx_q + 1'b1 == batch.count));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pend_q <= 1'b0;
		end else if (load) begin
			idx_q  <= '0;
			pend_q <= 1'b1;
		end else if (pend_q) begin
			if (batch.count == '0) pend_q <= 1'b0;
			else if (out_ready) begin
				if (idx_q + 1'b1 == batch.count) pend_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/json_event_tokenizer.sv
// ----------------------------------------------------------------------------
// json_event_tokenizer
// Streaming JSON tokenizer: one document byte in, zero to three SAX events out.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/in_ready  in_item_t  (data_byte, end_of_doc)
// out      out  out_valid/out_ready out_item_t (event, values, offsets)
//
// A byte is parsed in the cycle it is accepted; its events are shown from the
// next cycle, one per cycle from the batch register unless out stalls. A new
// byte is accepted in the cycle the last event of the previous byte is taken,
// so bytes with at most one event flow at one per cycle unless out stalls. The
// nesting stack is a bit vector with no reset; only levels already pushed are
// read. Reset clears the parse state; a stall on out simply holds in_ready low.
module json_event_tokenizer import jet_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	batch_t batch;
	logic   busy;
	logic   step;

	assign in_ready = !busy;
	assign step     = in_valid && in_ready;

	jet_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_item),
		.batch  (batch)
	);

	jet_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.batch     (batch),
		.busy      (busy),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_ready (out_ready)
	);

endmodule

FILE: rtl/jet_checker.sv
// ----------------------------------------------------------------------------
// jet_checker
// Port-level checks for the JSON event tokenizer.
// ----------------------------------------------------------------------------
`include "json_event_tokenizer_defines.svh"
module jet_checker import jet_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	`JET_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "out item changed while stalled")
	`JET_ASSERT_IMP(a_event_range, clk, arst_n, out_valid, out_item.event_res <= EV_ERROR, "event code out of range")
	`JET_ASSERT_IMP(a_no_in_midrun, clk, arst_n, out_valid && !out_item.last_of_run, !in_ready, "input taken mid run")
	`JET_ASSERT_IMP(a_int_only, clk, arst_n, out_valid && out_item.event_res != EV_INT, out_item.int_value == '0, "int value on non-int event")

endmodule

bind json_event_tokenizer jet_checker u_jet_checker (.*);
